// ===== src/ctg_pkg.sv =====
package ctg_pkg;

  // default CORDIC iteration count
  localparam int CORDIC_STEPS_DEF = 24;

  // angle constants
  localparam logic [35:0] TWO_PI_Q32 = 36'd26986075409;
  localparam logic [35:0] PI_Q32 = 36'd13493037705;
  localparam logic signed [33:0] PI_Q29 = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // range reduction: bias makes the product non-negative, then one
  // conditional subtract of 2pi << k per stage
  localparam int RED_STEPS = 31;
  localparam int RED_W = 66;

  // configuration register indexes
  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_SPEED = 3'd3;
  localparam logic [2:0] CFG_RATE = 3'd4;
  localparam logic [2:0] CFG_PHASE = 3'd5;

  // folded angle into the rotation pipeline
  typedef struct packed {
    logic valid;
    logic neg;
    logic signed [33:0] z;
  } angle_t;

  // cosine / sine out of the rotation pipeline, Q.30
  typedef struct packed {
    logic valid;
    logic signed [33:0] c;
    logic signed [33:0] s;
  } trig_t;

  // velocity into the vectoring pipeline
  typedef struct packed {
    logic valid;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } vec_in_t;

  // heading out of the vectoring pipeline
  typedef struct packed {
    logic valid;
    logic signed [31:0] z;
  } vec_out_t;

  // atan(2^-i) in Q3.29, rounded to nearest
  function automatic logic signed [33:0] atan_q29(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd421657428;
      1: v = 34'sd248918915;
      2: v = 34'sd131521918;
      3: v = 34'sd66762579;
      4: v = 34'sd33510843;
      5: v = 34'sd16771758;
      6: v = 34'sd8387925;
      7: v = 34'sd4194219;
      8: v = 34'sd2097141;
      9: v = 34'sd1048575;
      default: v = (i < 30) ? (34'sd1 <<< (29 - i)) : ((i == 30) ? 34'sd1 : 34'sd0);
    endcase
    return v;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/circular_trajectory_generator_core.sv =====
// Channel   Ports                                   Handshake
// input     in_sample_time                          start & !busy
// result    out_pos_x .. out_degenerate             out_valid strobe, one cycle
// config    cfg_index, cfg_data                     cfg_valid & cfg_ready
//
// One item per clock; busy is never raised and cfg_ready is always high.
// Each sample passes the product and the 2pi range reduction, the
// rotation and vectoring pipelines, and the multiply stages.
// Synchronous active-low reset clears the valid bits and sets the configuration registers to their defaults.
// The receiver cannot stall; every result appears exactly once.
module circular_trajectory_generator_core #(
  parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_heading,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_heading_rate,
  output logic signed [31:0] out_acc_x,
  output logic signed [31:0] out_acc_y,
  output logic signed [31:0] out_speed_out,
  output logic               out_degenerate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ctg_pkg::*;

  localparam int VEC_LAT = CORDIC_STEPS + 2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               deg;
  } side_t;

  logic signed [31:0] center_x_r, center_y_r, speed_r, rate_r, phase_r;
  logic [30:0]        radius_r;

  angle_t             angle;
  trig_t              trig;
  vec_in_t            vec_in;
  vec_out_t           vec_out;

  logic signed [65:0] prc, prs, pvx, pvy;
  logic signed [63:0] pax, pay;
  logic signed [33:0] rc_r, rs_r;
  logic               t1_v_r;
  side_t              t2_r;
  logic               t2_v_r;
  side_t              side_r [0:VEC_LAT-1];
  logic signed [31:0] heading_nxt;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r <= 31'd65536;
      speed_r <= '0;
      rate_r <= '0;
      phase_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_data;
        CFG_CENTER_Y: center_y_r <= cfg_data;
        CFG_RADIUS:   radius_r <= cfg_data[30:0];
        CFG_SPEED:    speed_r <= cfg_data;
        CFG_RATE:     rate_r <= cfg_data;
        CFG_PHASE:    phase_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ctg_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy),
    .in_time (in_sample_time),
    .rate    (rate_r),
    .phase   (phase_r),
    .angle_o (angle)
  );

  ctg_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
    .clk    (clk),
    .rst_n  (rst_n),
    .angle_i(angle),
    .trig_o (trig)
  );

  // r*cos and r*sin, back to Q16.16
  assign prc = $signed({1'b0, radius_r}) * trig.c;
  assign prs = $signed({1'b0, radius_r}) * trig.s;

  always_ff @(posedge clk) begin
    rc_r <= 34'(prc >>> 30);
    rs_r <= 34'(prs >>> 30);
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else begin
      t1_v_r <= trig.valid;
    end
  end

  // position and velocity
  assign pvx = rs_r * rate_r;
  assign pvy = rc_r * rate_r;

  always_ff @(posedge clk) begin
    t2_r.pos_x <= sat32(68'(center_x_r) + 68'(rc_r));
    t2_r.pos_y <= sat32(68'(center_y_r) + 68'(rs_r));
    t2_r.vx <= sat32(-(68'(pvx >>> 16)));
    t2_r.vy <= sat32(68'(pvy >>> 16));
    t2_r.deg <= (sat32(-(68'(pvx >>> 16))) == 0) && (sat32(68'(pvy >>> 16)) == 0);
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else begin
      t2_v_r <= t1_v_r;
    end
  end

  assign vec_in.valid = t2_v_r;
  assign vec_in.vx = t2_r.vx;
  assign vec_in.vy = t2_r.vy;

  ctg_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan2 (
    .clk  (clk),
    .rst_n(rst_n),
    .vec_i(vec_in),
    .vec_o(vec_out)
  );

  // side data waits for the heading
  always_ff @(posedge clk) begin
    side_r[0] <= t2_r;
  end

  for (genvar k = 1; k < VEC_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // acceleration and output register
  assign pax = side_r[VEC_LAT-1].vy * rate_r;
  assign pay = side_r[VEC_LAT-1].vx * rate_r;
  assign heading_nxt = side_r[VEC_LAT-1].deg ? 32'sd0 : vec_out.z;

  always_ff @(posedge clk) begin
    out_pos_x <= side_r[VEC_LAT-1].pos_x;
    out_pos_y <= side_r[VEC_LAT-1].pos_y;
    out_heading <= heading_nxt;
    out_vel_x <= side_r[VEC_LAT-1].vx;
    out_vel_y <= side_r[VEC_LAT-1].vy;
    out_heading_rate <= side_r[VEC_LAT-1].deg ? 32'sd0 : rate_r;
    out_acc_x <= sat32(-(68'(pax >>> 16)));
    out_acc_y <= sat32(68'(pay >>> 16));
    out_speed_out <= speed_r;
    out_degenerate <= side_r[VEC_LAT-1].deg;
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vec_out.valid;
    end
  end

endmodule

// ===== src/ctg_phase.sv =====
module ctg_phase (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [31:0]         in_time,
  input  logic signed [31:0]  rate,
  input  logic signed [31:0]  phase,
  output ctg_pkg::angle_t     angle_o
);
  import ctg_pkg::*;

  localparam logic [RED_W-1:0] RED_BIAS = RED_W'(TWO_PI_Q32) << (RED_STEPS - 2);
  localparam logic [36:0] PHASE_BIAS = 37'(PI_Q32) + 37'(TWO_PI_Q32);
  localparam logic [36:0] TWO_PI_37 = 37'(TWO_PI_Q32);

  logic signed [64:0] prod_r;
  logic               prod_v_r;
  logic [RED_W-1:0]   red_r [0:RED_STEPS];
  logic               red_v_r [0:RED_STEPS];
  logic [36:0]        u1_r, u2_r, u3_r;
  logic               u1_v_r, u2_v_r, u3_v_r;
  logic signed [33:0] a_nxt;
  angle_t             angle_r, angle_nxt;

  // rate times time, Q.32
  always_ff @(posedge clk) begin
    prod_r <= rate * $signed({1'b0, in_time});
    red_r[0] <= RED_W'(prod_r) + RED_BIAS;
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      red_v_r[0] <= 1'b0;
    end else begin
      prod_v_r <= in_valid;
      red_v_r[0] <= prod_v_r;
    end
  end

  // restoring reduction, one multiple of 2pi per stage
  for (genvar g = 0; g < RED_STEPS; g++) begin : g_red
    localparam logic [RED_W-1:0] MOD = RED_W'(TWO_PI_Q32) << (RED_STEPS - 1 - g);
    always_ff @(posedge clk) begin
      red_r[g+1] <= (red_r[g] >= MOD) ? red_r[g] - MOD : red_r[g];
      if (!rst_n) begin
        red_v_r[g+1] <= 1'b0;
      end else begin
        red_v_r[g+1] <= red_v_r[g];
      end
    end
  end

  // add start phase and pi, reduce again (sum lies in [0, 4*2pi))
  always_ff @(posedge clk) begin
    u1_r <= 37'(red_r[RED_STEPS]) + 37'($signed({phase, 3'b000})) + PHASE_BIAS;
    u2_r <= (u1_r >= (TWO_PI_37 << 1)) ? u1_r - (TWO_PI_37 << 1) : u1_r;
    u3_r <= (u2_r >= TWO_PI_37) ? u2_r - TWO_PI_37 : u2_r;
    if (!rst_n) begin
      u1_v_r <= 1'b0;
      u2_v_r <= 1'b0;
      u3_v_r <= 1'b0;
    end else begin
      u1_v_r <= red_v_r[RED_STEPS];
      u2_v_r <= u1_v_r;
      u3_v_r <= u2_v_r;
    end
  end

  // to Q3.29 in [-pi, pi), fold into [-pi/2, pi/2]
  always_comb begin
    a_nxt = $signed({2'b00, u3_r[34:3]}) - PI_Q29;
    angle_nxt.valid = u3_v_r;
    angle_nxt.neg = 1'b0;
    angle_nxt.z = a_nxt;
    if (a_nxt > HALF_PI_Q29) begin
      angle_nxt.z = a_nxt - PI_Q29;
      angle_nxt.neg = 1'b1;
    end else if (a_nxt < -HALF_PI_Q29) begin
      angle_nxt.z = a_nxt + PI_Q29;
      angle_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule

// ===== src/ctg_sincos.sv =====
module ctg_sincos #(
  parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctg_pkg::angle_t angle_i,
  output ctg_pkg::trig_t  trig_o
);
  import ctg_pkg::*;

  logic signed [33:0] x_r [0:CORDIC_STEPS];
  logic signed [33:0] y_r [0:CORDIC_STEPS];
  logic signed [33:0] z_r [0:CORDIC_STEPS];
  logic               n_r [0:CORDIC_STEPS];
  logic               v_r [0:CORDIC_STEPS];
  trig_t              trig_r;

  // load start vector
  always_ff @(posedge clk) begin
    x_r[0] <= GAIN_Q30;
    y_r[0] <= '0;
    z_r[0] <= angle_i.z;
    n_r[0] <= angle_i.neg;
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= angle_i.valid;
    end
  end

  // rotation steps
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    localparam logic signed [33:0] ATN = atan_q29(g);
    always_ff @(posedge clk) begin
      if (z_r[g] >= 0) begin
        x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] - ATN;
      end else begin
        x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] + ATN;
      end
      n_r[g+1] <= n_r[g];
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    trig_r.c <= n_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    trig_r.s <= n_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    if (!rst_n) begin
      trig_r.valid <= 1'b0;
    end else begin
      trig_r.valid <= v_r[CORDIC_STEPS];
    end
  end

  assign trig_o = trig_r;

endmodule

// ===== src/ctg_atan2.sv =====
module ctg_atan2 #(
  parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctg_pkg::vec_in_t  vec_i,
  output ctg_pkg::vec_out_t vec_o
);
  import ctg_pkg::*;

  logic signed [50:0] x_r [0:CORDIC_STEPS];
  logic signed [50:0] y_r [0:CORDIC_STEPS];
  logic signed [33:0] z_r [0:CORDIC_STEPS];
  logic               v_r [0:CORDIC_STEPS];
  logic signed [50:0] x0, y0, x_nxt, y_nxt;
  logic signed [33:0] z_nxt, zc;
  vec_out_t           vec_r;

  // scale by 2^16 and turn into the right half plane
  always_comb begin
    x0 = $signed({{3{vec_i.vx[31]}}, vec_i.vx, 16'h0000});
    y0 = $signed({{3{vec_i.vy[31]}}, vec_i.vy, 16'h0000});
    x_nxt = x0;
    y_nxt = y0;
    z_nxt = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x_nxt = y0;
        y_nxt = -x0;
        z_nxt = HALF_PI_Q29;
      end else begin
        x_nxt = -y0;
        y_nxt = x0;
        z_nxt = -HALF_PI_Q29;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= x_nxt;
    y_r[0] <= y_nxt;
    z_r[0] <= z_nxt;
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= vec_i.valid;
    end
  end

  // vectoring steps drive y toward zero
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    localparam logic signed [33:0] ATN = atan_q29(g);
    always_ff @(posedge clk) begin
      if (y_r[g] > 0) begin
        x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] + ATN;
      end else begin
        x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
        y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
        z_r[g+1] <= z_r[g] - ATN;
      end
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end
  end

  // clamp to +-pi
  always_comb begin
    zc = z_r[CORDIC_STEPS];
    if (zc > PI_Q29) zc = PI_Q29;
    if (zc < -PI_Q29) zc = -PI_Q29;
  end

  always_ff @(posedge clk) begin
    vec_r.z <= zc[31:0];
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else begin
      vec_r.valid <= v_r[CORDIC_STEPS];
    end
  end

  assign vec_o = vec_r;

endmodule

// ===== tb/circular_trajectory_generator_core_tb.sv =====
module circular_trajectory_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctg_pkg::*;

  // pending item kinds
  localparam logic [1:0] K_SAMPLE = 2'd0;
  localparam logic [1:0] K_CFG = 2'd1;
  localparam logic [1:0] K_DRAIN = 2'd2;

  // register indexes with no register behind them
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  // angle constants in 64-bit signed form
  localparam longint TWO_PI_32 = 64'sd26986075409;
  localparam longint PI_32 = 64'sd13493037705;
  localparam longint PI_29 = 64'sd1686629713;
  localparam longint HALF_PI_29 = 64'sd843314857;
  localparam longint GAIN_30 = 64'sd652032874;
  localparam int STEPS = CORDIC_STEPS_DEF;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  idx;
    logic [31:0] data;
    int          gap;
  } pend_item_t;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, heading, vel_x, vel_y;
    logic signed [31:0] heading_rate, acc_x, acc_y, speed_out;
    logic               degenerate;
  } traj_t;

  logic clk, rst_n, start, busy, cfg_valid, cfg_ready;
  logic [31:0] in_sample_time, cfg_data;
  logic [2:0] cfg_index;
  logic out_valid, out_degenerate;
  logic signed [31:0] out_pos_x, out_pos_y, out_heading, out_vel_x, out_vel_y;
  logic signed [31:0] out_heading_rate, out_acc_x, out_acc_y, out_speed_out;

  circular_trajectory_generator_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_time(in_sample_time), .out_valid(out_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y),
    .out_heading_rate(out_heading_rate), .out_acc_x(out_acc_x),
    .out_acc_y(out_acc_y), .out_speed_out(out_speed_out),
    .out_degenerate(out_degenerate), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pend_item_t pend_q[$];
  traj_t      traj_q[$];
  int         n_err;
  longint     atan_tab[32];

  // shadow registers
  longint m_cx, m_cy, m_radius, m_speed, m_rate, m_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // atan(2^-i) in Q3.29, from the arctan series for i above zero, rounded to nearest
  initial begin
    longint unsigned v, term;
    int e;
    atan_tab[0] = 64'sd421657428;
    for (int i = 1; i < 32; i++) begin
      v = 0;
      for (int k = 0; ; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) break;
        term = (64'd1 << e) / longint'(2 * k + 1);
        v = (k & 1) ? v - term : v + term;
      end
      atan_tab[i] = longint'((v + (64'd1 << 32)) >> 33);
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void rotate_unit(longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit neg;
    x = GAIN_30;
    y = 0;
    z = ang;
    neg = 0;
    // fold to +-pi/2, negate afterwards
    if (z > HALF_PI_29) begin
      z -= PI_29;
      neg = 1;
    end else if (z < -HALF_PI_29) begin
      z += PI_29;
      neg = 1;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint vector_angle(longint vy, longint vx);
    longint x, y, z, t, nx;
    x = vx * 65536;
    y = vy * 65536;
    z = 0;
    // left half plane turned by +-pi/2
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_29;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_29;
      end
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end
      x = nx;
    end
    if (z > PI_29) z = PI_29;
    if (z < -PI_29) z = -PI_29;
    return z;
  endfunction

  function automatic traj_t eval_trajectory(logic [31:0] t_in);
    traj_t  r;
    longint tt, p, u, a, c, s, rc, rs, vx, vy;
    tt = longint'({32'd0, t_in});
    p = (m_rate * tt) % TWO_PI_32;
    if (p < 0) p += TWO_PI_32;
    u = (p + m_phase * 8 + PI_32) % TWO_PI_32;
    if (u < 0) u += TWO_PI_32;
    a = (u >>> 3) - PI_29;
    rotate_unit(a, c, s);
    rc = (m_radius * c) >>> 30;
    rs = (m_radius * s) >>> 30;
    vx = clamp32(-((rs * m_rate) >>> 16));
    vy = clamp32((rc * m_rate) >>> 16);
    r.pos_x = 32'(clamp32(m_cx + rc));
    r.pos_y = 32'(clamp32(m_cy + rs));
    r.vel_x = 32'(vx);
    r.vel_y = 32'(vy);
    r.acc_x = 32'(clamp32(-((vy * m_rate) >>> 16)));
    r.acc_y = 32'(clamp32((vx * m_rate) >>> 16));
    r.speed_out = 32'(m_speed);
    r.degenerate = (vx == 0 && vy == 0);
    r.heading = r.degenerate ? 32'sd0 : 32'(vector_angle(vy, vx));
    r.heading_rate = r.degenerate ? 32'sd0 : 32'(m_rate);
    return r;
  endfunction

  function automatic void chk(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, got_v);
      n_err++;
    end
  endfunction

  // driver: accepts items, updates shadow registers, issues the next item
  always @(posedge clk) begin
    int         wait_cnt;
    bit         nx_start, nx_cfg;
    pend_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_index <= 3'd0;
      cfg_data <= 32'd0;
      in_sample_time <= 32'd0;
      wait_cnt = 0;
      m_cx = 0; m_cy = 0; m_radius = 65536; m_speed = 0; m_rate = 0; m_phase = 0;
    end else begin
      nx_start = start && busy;
      nx_cfg = cfg_valid && !cfg_ready;
      if (start && !busy) traj_q.push_back(eval_trajectory(in_sample_time));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER_X: m_cx = longint'(signed'(cfg_data));
          CFG_CENTER_Y: m_cy = longint'(signed'(cfg_data));
          CFG_RADIUS:   m_radius = longint'({33'd0, cfg_data[30:0]});
          CFG_SPEED:    m_speed = longint'(signed'(cfg_data));
          CFG_RATE:     m_rate = longint'(signed'(cfg_data));
          CFG_PHASE:    m_phase = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (!nx_start && !nx_cfg) begin
        if (wait_cnt > 0) begin
          wait_cnt--;
        end else if (pend_q.size() > 0) begin
          it = pend_q[0];
          if (it.kind == K_SAMPLE) begin
            void'(pend_q.pop_front());
            nx_start = 1;
            in_sample_time <= it.data;
            wait_cnt = it.gap;
          end else if (traj_q.size() == 0 && !start && !cfg_valid) begin
            // registers change only with nothing in flight
            void'(pend_q.pop_front());
            wait_cnt = it.gap;
            if (it.kind == K_CFG) begin
              nx_cfg = 1;
              cfg_index <= it.idx;
              cfg_data <= it.data;
            end
          end
        end
      end
      start <= nx_start;
      cfg_valid <= nx_cfg;
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk) begin
    traj_t e;
    if (rst_n && out_valid) begin
      if (traj_q.size() == 0) begin
        $error("result with no prediction waiting");
        n_err++;
      end else begin
        e = traj_q.pop_front();
        chk("pos_x", e.pos_x, out_pos_x);
        chk("pos_y", e.pos_y, out_pos_y);
        chk("heading", e.heading, out_heading);
        chk("vel_x", e.vel_x, out_vel_x);
        chk("vel_y", e.vel_y, out_vel_y);
        chk("heading_rate", e.heading_rate, out_heading_rate);
        chk("acc_x", e.acc_x, out_acc_x);
        chk("acc_y", e.acc_y, out_acc_y);
        chk("speed_out", e.speed_out, out_speed_out);
        chk("degenerate", {31'd0, e.degenerate}, {31'd0, out_degenerate});
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_sample(logic [31:0] t);
    pend_q.push_back('{K_SAMPLE, 3'd0, t, rand_gap()});
  endtask

  task automatic add_cfg(logic [2:0] idx, logic [31:0] d);
    pend_q.push_back('{K_CFG, idx, d, rand_gap()});
  endtask

  // stimulus
  initial begin
    logic [31:0] v;
    n_err = 0;
    rst_n = 1'b0;

    // reset settings: zero rate, degenerate
    add_sample(32'h0000_0000);
    add_sample(32'hFFFF_FFFF);
    // extremes: largest and smallest register values
    add_cfg(CFG_CENTER_X, 32'h7FFF_FFFF);
    add_cfg(CFG_CENTER_Y, 32'h8000_0000);
    add_cfg(CFG_RADIUS, 32'h7FFF_FFFF);
    add_cfg(CFG_SPEED, 32'h8000_0000);
    add_cfg(CFG_RATE, 32'h7FFF_FFFF);
    add_cfg(CFG_PHASE, 32'd1686629713);
    add_sample(32'h0000_0000);
    add_sample(32'hFFFF_FFFF);
    add_sample(32'h8000_0000);
    // phase beyond pi wraps, most negative rate
    add_cfg(CFG_PHASE, 32'h7FFF_FFFF);
    add_cfg(CFG_RATE, 32'h8000_0000);
    add_sample(32'h0001_0000);
    add_sample(32'hFFFF_FFFF);
    // zero radius gives zero velocity
    add_cfg(CFG_RADIUS, 32'h0000_0000);
    add_sample(32'h1234_5678);
    // spare indexes are ignored
    add_cfg(CFG_SPARE_6, 32'hFFFF_FFFF);
    add_cfg(CFG_SPARE_7, 32'hFFFF_FFFF);
    // ordinary circle, radius 2, rate 1
    add_cfg(CFG_CENTER_X, 32'h0000_0000);
    add_cfg(CFG_CENTER_Y, 32'h0000_0000);
    add_cfg(CFG_RADIUS, 32'h8002_0000);
    add_cfg(CFG_SPEED, 32'h0002_0000);
    add_cfg(CFG_RATE, 32'h0001_0000);
    add_cfg(CFG_PHASE, -32'sd1686629713);
    for (int i = 0; i < 8; i++) add_sample(32'h0000_6000 * i);

    // random settings
    for (int ph = 0; ph < 8; ph++) begin
      add_cfg(CFG_CENTER_X, ($urandom_range(0, 3) == 0) ? $urandom
                                                       : $urandom_range(0, 32'h000F_FFFF)
                                                         - 32'h0008_0000);
      add_cfg(CFG_CENTER_Y, ($urandom_range(0, 3) == 0) ? $urandom
                                                       : $urandom_range(0, 32'h000F_FFFF)
                                                         - 32'h0008_0000);
      add_cfg(CFG_RADIUS, ($urandom_range(0, 3) == 0) ? $urandom
                                                     : $urandom_range(0, 32'h0040_0000));
      add_cfg(CFG_SPEED, $urandom);
      add_cfg(CFG_RATE, ($urandom_range(0, 3) == 0) ? $urandom
                                                   : $urandom_range(0, 32'h0008_0000)
                                                     - 32'h0004_0000);
      // phase spread over [-pi, pi]
      v = $urandom_range(0, 32'd3373259426) - 32'd1686629713;
      add_cfg(CFG_PHASE, ($urandom_range(0, 4) == 0) ? $urandom : v);
      if ($urandom_range(0, 3) == 0) begin
        add_cfg(3'(CFG_SPARE_6 + $urandom_range(0, 1)), $urandom);
      end
      for (int i = 0; i < 200; i++) begin
        if (i == 100) pend_q.push_back('{K_DRAIN, 3'd0, 32'd0, rand_gap()});
        add_sample(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h000A_0000));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pend_q.size() != 0 || start || traj_q.size() != 0);
    repeat (200) @(posedge clk);
    if (n_err == 0 && traj_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
